@@ rtl/rc2_pkg.sv @@
// ----------------------------------------------------------------------------
// RC2 CBC cipher package
// Shared codes, types, the PITABLE permutation and 16-bit rotate helpers.
// ----------------------------------------------------------------------------
package rc2_pkg;

   localparam int MAX_KEY_BYTES = 16;
   localparam int KEY_LEN_W     = 5;
   localparam int EFF_BITS_W    = 11;
   localparam int BLOCK_W       = 64;
   localparam logic [EFF_BITS_W-1:0] MAX_EFF_BITS = 11'd1024;

   typedef enum logic [1:0] {
      OP_EXPAND  = 2'd0,
      OP_ENCRYPT = 2'd1,
      OP_DECRYPT = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2,
      CSR_EFF_BITS = 2'd3
   } csr_index_type;

   // control of the shared round unit
   typedef struct packed {
      logic       decrypt;
      logic       mash;
      logic [1:0] word_sel;
   } mix_ctrl_type;

   localparam logic [7:0] PI_TABLE [0:255] = '{
      8'hd9,8'h78,8'hf9,8'hc4,8'h19,8'hdd,8'hb5,8'hed,
      8'h28,8'he9,8'hfd,8'h79,8'h4a,8'ha0,8'hd8,8'h9d,
      8'hc6,8'h7e,8'h37,8'h83,8'h2b,8'h76,8'h53,8'h8e,
      8'h62,8'h4c,8'h64,8'h88,8'h44,8'h8b,8'hfb,8'ha2,
      8'h17,8'h9a,8'h59,8'hf5,8'h87,8'hb3,8'h4f,8'h13,
      8'h61,8'h45,8'h6d,8'h8d,8'h09,8'h81,8'h7d,8'h32,
      8'hbd,8'h8f,8'h40,8'heb,8'h86,8'hb7,8'h7b,8'h0b,
      8'hf0,8'h95,8'h21,8'h22,8'h5c,8'h6b,8'h4e,8'h82,
      8'h54,8'hd6,8'h65,8'h93,8'hce,8'h60,8'hb2,8'h1c,
      8'h73,8'h56,8'hc0,8'h14,8'ha7,8'h8c,8'hf1,8'hdc,
      8'h12,8'h75,8'hca,8'h1f,8'h3b,8'hbe,8'he4,8'hd1,
      8'h42,8'h3d,8'hd4,8'h30,8'ha3,8'h3c,8'hb6,8'h26,
      8'h6f,8'hbf,8'h0e,8'hda,8'h46,8'h69,8'h07,8'h57,
      8'h27,8'hf2,8'h1d,8'h9b,8'hbc,8'h94,8'h43,8'h03,
      8'hf8,8'h11,8'hc7,8'hf6,8'h90,8'hef,8'h3e,8'he7,
      8'h06,8'hc3,8'hd5,8'h2f,8'hc8,8'h66,8'h1e,8'hd7,
      8'h08,8'he8,8'hea,8'hde,8'h80,8'h52,8'hee,8'hf7,
      8'h84,8'haa,8'h72,8'hac,8'h35,8'h4d,8'h6a,8'h2a,
      8'h96,8'h1a,8'hd2,8'h71,8'h5a,8'h15,8'h49,8'h74,
      8'h4b,8'h9f,8'hd0,8'h5e,8'h04,8'h18,8'ha4,8'hec,
      8'hc2,8'he0,8'h41,8'h6e,8'h0f,8'h51,8'hcb,8'hcc,
      8'h24,8'h91,8'haf,8'h50,8'ha1,8'hf4,8'h70,8'h39,
      8'h99,8'h7c,8'h3a,8'h85,8'h23,8'hb8,8'hb4,8'h7a,
      8'hfc,8'h02,8'h36,8'h5b,8'h25,8'h55,8'h97,8'h31,
      8'h2d,8'h5d,8'hfa,8'h98,8'he3,8'h8a,8'h92,8'hae,
      8'h05,8'hdf,8'h29,8'h10,8'h67,8'h6c,8'hba,8'hc9,
      8'hd3,8'h00,8'he6,8'hcf,8'he1,8'h9e,8'ha8,8'h2c,
      8'h63,8'h16,8'h01,8'h3f,8'h58,8'he2,8'h89,8'ha9,
      8'h0d,8'h38,8'h34,8'h1b,8'hab,8'h33,8'hff,8'hb0,
      8'hbb,8'h48,8'h0c,8'h5f,8'hb9,8'hb1,8'hcd,8'h2e,
      8'hc5,8'hf3,8'hdb,8'h47,8'he5,8'ha5,8'h9c,8'h77,
      8'h0a,8'ha6,8'h20,8'h68,8'hfe,8'h7f,8'hc1,8'had
   };

   // rotate amounts per word: 1, 2, 3, 5
   function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [1:0] sel);
      logic [15:0] r;
      case (sel)
         2'd0:    r = {x[14:0], x[15]};
         2'd1:    r = {x[13:0], x[15:14]};
         2'd2:    r = {x[12:0], x[15:13]};
         default: r = {x[10:0], x[15:11]};
      endcase
      return r;
   endfunction

   function automatic logic [15:0] rotr16(input logic [15:0] x, input logic [1:0] sel);
      logic [15:0] r;
      case (sel)
         2'd0:    r = {x[0], x[15:1]};
         2'd1:    r = {x[1:0], x[15:2]};
         2'd2:    r = {x[2:0], x[15:3]};
         default: r = {x[4:0], x[15:5]};
      endcase
      return r;
   endfunction

endpackage

@@ rtl/rc2_if.sv @@
// ----------------------------------------------------------------------------
// RC2 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rc2_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] block_in;
   logic [63:0] init_vector;
   logic        start_req;

   modport source (output valid, op, block_in, init_vector, start_req, input ready);
   modport sink   (input valid, op, block_in, init_vector, start_req, output ready);
endinterface

interface rc2_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_out;

   modport source (output valid, block_out, input ready);
   modport sink   (input valid, block_out, output ready);
endinterface

@@ rtl/rc2_mix_unit.sv @@
// ----------------------------------------------------------------------------
// RC2 round unit
// One MIX or MASH word update, forward or inverse, per use.
// ----------------------------------------------------------------------------
module rc2_mix_unit
   import rc2_pkg::*;
(
   input  mix_ctrl_type     ctrl,
   input  logic [3:0][15:0] words,
   input  logic [15:0]      key_word,
   output logic [15:0]      word_out
);

   logic [15:0] a, b, c, self_w, mix_f;

   always_comb begin
      self_w = words[ctrl.word_sel];
      a      = words[ctrl.word_sel + 2'd3];
      b      = words[ctrl.word_sel + 2'd2];
      c      = words[ctrl.word_sel + 2'd1];
      mix_f  = (a & b) + (~a & c);
      if (ctrl.mash) begin
         word_out = ctrl.decrypt ? self_w - key_word : self_w + key_word;
      end else if (ctrl.decrypt) begin
         word_out = rotr16(self_w, ctrl.word_sel) - key_word - mix_f;
      end else begin
         word_out = rotl16(self_w + key_word + mix_f, ctrl.word_sel);
      end
   end

endmodule

@@ rtl/rc2_cbc_cipher_core.sv @@
// ----------------------------------------------------------------------------
// RC2 CBC cipher core
// Key expansion, block encrypt/decrypt with CBC chaining, one request at a time.
// ----------------------------------------------------------------------------
// Encrypt/decrypt: 72 word steps (CIPH_RD, CIPH_WR), paced by the registered key table
//   read, then ST_FINISH loads the response when the output register is free.
// Key expansion: fill t key bytes, PITABLE bytes t..127, byte 128-t8, back-fill to 0, copy
//   into the 64-word key table (t key bytes, t8 eff. bytes). One request in flight.
// The next request is taken the cycle after the response is loaded. Reset: sync, active high;
//   clears control, config (key length to 16) and chain; tables undefined until expand.
module rc2_cbc_cipher_core
   import rc2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rc2_req_if.sink     req_chan,
   rc2_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_FILL    = 13'b0000000000010,
      ST_GEN_RD  = 13'b0000000000100,
      ST_GEN_WR  = 13'b0000000001000,
      ST_TOP_RD  = 13'b0000000010000,
      ST_TOP_WR  = 13'b0000000100000,
      ST_BACK_RD = 13'b0000001000000,
      ST_BACK_WR = 13'b0000010000000,
      ST_COPY_RD = 13'b0000100000000,
      ST_COPY_WR = 13'b0001000000000,
      ST_CIPH_RD = 13'b0010000000000,
      ST_CIPH_WR = 13'b0100000000000,
      ST_FINISH  = 13'b1000000000000
   } state_type;

   // configuration registers
   logic [63:0]           key_lo_ff, key_hi_ff;
   logic [KEY_LEN_W-1:0]  key_len_ff;
   logic [EFF_BITS_W-1:0] eff_bits_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [7:0]       idx_ff, idx_in;
   logic [7:0]       last_ff, last_in;
   logic [7:0]       low_byte_ff, low_byte_in;
   logic [KEY_LEN_W-1:0] t_ff, t_in;
   logic [7:0]       t8_ff, t8_in;
   logic [7:0]       mask_ff, mask_in;
   logic [3:0]       rnd_ff, rnd_in;
   logic [1:0]       wi_ff, wi_in;
   logic             mash_ff, mash_in;
   logic             dec_ff, dec_in;

   // datapath
   logic [3:0][15:0] word_ff, word_in;
   logic [63:0]      prev_ff, prev_in;
   logic [63:0]      blk_ff, blk_in;
   logic [63:0]      chain_ff, chain_in;
   logic [63:0]      result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff, rsp_data_in;

   // memories
   logic [7:0]  buf_mem [0:127];
   logic [7:0]  buf_rd_ff;
   logic [6:0]  buf_raddr, buf_waddr;
   logic [7:0]  buf_wdata;
   logic        buf_we;
   logic [15:0] kt_mem [0:63];
   logic [15:0] kt_rd_ff;
   logic [5:0]  kt_raddr;
   logic        kt_we;

   logic [7:0]  pi_idx, pi_val;
   logic [15:0] unit_out;
   logic [3:0][15:0] new_words;
   mix_ctrl_type     unit_ctrl;
   logic [15:0][7:0] key_all;
   logic             accept;

   // effective length decode for expansion
   logic [KEY_LEN_W-1:0]  t_dec;
   logic [EFF_BITS_W-1:0] bits_dec;
   logic [EFF_BITS_W-1:0] bits_round;
   logic [2:0]            mask_shift;

   assign key_all = {key_hi_ff, key_lo_ff};
   assign accept  = req_chan.valid && req_chan.ready;
   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.block_out = rsp_data_ff;

   always_comb begin
      if (key_len_ff == '0) begin
         t_dec = KEY_LEN_W'(1);
      end else if (key_len_ff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         t_dec = KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         t_dec = key_len_ff;
      end
      if (eff_bits_ff == '0) begin
         bits_dec = EFF_BITS_W'({t_dec, 3'b000});
      end else if (eff_bits_ff > MAX_EFF_BITS) begin
         bits_dec = MAX_EFF_BITS;
      end else begin
         bits_dec = eff_bits_ff;
      end
      bits_round = bits_dec + EFF_BITS_W'(7);
      mask_shift = 3'd0 - bits_dec[2:0];
   end

   // shared round unit
   assign unit_ctrl = '{decrypt: dec_ff, mash: mash_ff, word_sel: wi_ff};

   rc2_mix_unit u_mix (
      .ctrl     (unit_ctrl),
      .words    (word_ff),
      .key_word (kt_rd_ff),
      .word_out (unit_out)
   );

   always_comb begin
      new_words        = word_ff;
      new_words[wi_ff] = unit_out;
   end

   // key table address: sequential subkey for MIX, data dependent for MASH
   assign kt_raddr = mash_ff ? word_ff[wi_ff + 2'd3][5:0] : {rnd_ff, wi_ff};

   // buffer read address per expansion phase
   always_comb begin
      unique case (state_ff)
         ST_GEN_RD:  buf_raddr = 7'(idx_ff - 8'(t_ff));
         ST_BACK_RD: buf_raddr = 7'(idx_ff - 8'd1 + t8_ff);
         default:    buf_raddr = idx_ff[6:0];
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_TOP_WR:  pi_idx = buf_rd_ff & mask_ff;
         ST_BACK_WR: pi_idx = last_ff ^ buf_rd_ff;
         default:    pi_idx = last_ff + buf_rd_ff;
      endcase
   end
   assign pi_val = PI_TABLE[pi_idx];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      low_byte_in  = low_byte_ff;
      t_in         = t_ff;
      t8_in        = t8_ff;
      mask_in      = mask_ff;
      rnd_in       = rnd_ff;
      wi_in        = wi_ff;
      mash_in      = mash_ff;
      dec_in       = dec_ff;
      word_in      = word_ff;
      prev_in      = prev_ff;
      blk_in       = blk_ff;
      chain_in     = chain_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      buf_we       = 1'b0;
      buf_waddr    = idx_ff[6:0];
      buf_wdata    = pi_val;
      kt_we        = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_in   = req_chan.start_req ? req_chan.init_vector : chain_ff;
               blk_in    = req_chan.block_in;
               result_in = '0;
               mash_in   = 1'b0;
               case (op_type'(req_chan.op))
                  OP_EXPAND: begin
                     t_in     = t_dec;
                     t8_in    = bits_round[10:3];
                     mask_in  = 8'hFF >> mask_shift;
                     idx_in   = '0;
                     state_in = ST_FILL;
                  end
                  OP_ENCRYPT: begin
                     word_in  = req_chan.block_in ^ prev_in;
                     dec_in   = 1'b0;
                     rnd_in   = 4'd0;
                     wi_in    = 2'd0;
                     state_in = ST_CIPH_RD;
                  end
                  OP_DECRYPT: begin
                     word_in  = req_chan.block_in;
                     dec_in   = 1'b1;
                     rnd_in   = 4'd15;
                     wi_in    = 2'd3;
                     state_in = ST_CIPH_RD;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FILL: begin
            buf_we    = 1'b1;
            buf_wdata = key_all[idx_ff[3:0]];
            last_in   = key_all[idx_ff[3:0]];
            if (idx_ff == 8'(t_ff) - 8'd1) begin
               idx_in   = 8'(t_ff);
               state_in = ST_GEN_RD;
            end else begin
               idx_in = idx_ff + 8'd1;
            end
         end
         ST_GEN_RD: state_in = ST_GEN_WR;
         ST_GEN_WR: begin
            buf_we  = 1'b1;
            last_in = pi_val;
            if (idx_ff == 8'd127) begin
               idx_in   = 8'd128 - t8_ff;
               state_in = ST_TOP_RD;
            end else begin
               idx_in   = idx_ff + 8'd1;
               state_in = ST_GEN_RD;
            end
         end
         ST_TOP_RD: state_in = ST_TOP_WR;
         ST_TOP_WR: begin
            buf_we  = 1'b1;
            last_in = pi_val;
            if (idx_ff == 8'd0) begin
               state_in = ST_COPY_RD;
            end else begin
               state_in = ST_BACK_RD;
            end
         end
         ST_BACK_RD: state_in = ST_BACK_WR;
         ST_BACK_WR: begin
            buf_we    = 1'b1;
            buf_waddr = 7'(idx_ff - 8'd1);
            last_in   = pi_val;
            idx_in    = idx_ff - 8'd1;
            if (idx_ff == 8'd1) begin
               state_in = ST_COPY_RD;
            end else begin
               state_in = ST_BACK_RD;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (idx_ff[0]) begin
               kt_we = 1'b1;
            end else begin
               low_byte_in = buf_rd_ff;
            end
            if (idx_ff == 8'd127) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + 8'd1;
               state_in = ST_COPY_RD;
            end
         end
         ST_CIPH_RD: state_in = ST_CIPH_WR;
         ST_CIPH_WR: begin
            word_in  = new_words;
            state_in = ST_CIPH_RD;
            if (!dec_ff) begin
               if (wi_ff != 2'd3) begin
                  wi_in = wi_ff + 2'd1;
               end else if (mash_ff) begin
                  mash_in = 1'b0;
                  rnd_in  = rnd_ff + 4'd1;
                  wi_in   = 2'd0;
               end else if (rnd_ff == 4'd4 || rnd_ff == 4'd10) begin
                  mash_in = 1'b1;
                  wi_in   = 2'd0;
               end else if (rnd_ff == 4'd15) begin
                  result_in = new_words;
                  chain_in  = new_words;
                  state_in  = ST_FINISH;
               end else begin
                  rnd_in = rnd_ff + 4'd1;
                  wi_in  = 2'd0;
               end
            end else begin
               if (wi_ff != 2'd0) begin
                  wi_in = wi_ff - 2'd1;
               end else if (mash_ff) begin
                  mash_in = 1'b0;
                  wi_in   = 2'd3;
               end else if (rnd_ff == 4'd0) begin
                  result_in = new_words ^ prev_ff;
                  chain_in  = blk_ff;
                  state_in  = ST_FINISH;
               end else begin
                  // inverse MASH precedes rounds 10 and 4
                  rnd_in  = rnd_ff - 4'd1;
                  mash_in = (rnd_ff == 4'd11) || (rnd_ff == 4'd5);
                  wi_in   = 2'd3;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mash_ff      <= 1'b0;
         dec_ff       <= 1'b0;
         rnd_ff       <= '0;
         wi_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
         key_len_ff   <= KEY_LEN_W'(16);
         eff_bits_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         mash_ff      <= mash_in;
         dec_ff       <= dec_in;
         rnd_ff       <= rnd_in;
         wi_ff        <= wi_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_KEY_LOW:  key_lo_ff   <= csr_write_data;
               CSR_KEY_HIGH: key_hi_ff   <= csr_write_data;
               CSR_KEY_LEN:  key_len_ff  <= csr_write_data[KEY_LEN_W-1:0];
               CSR_EFF_BITS: eff_bits_ff <= csr_write_data[EFF_BITS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      low_byte_ff <= low_byte_in;
      t_ff        <= t_in;
      t8_ff       <= t8_in;
      mask_ff     <= mask_in;
      word_ff     <= word_in;
      prev_ff     <= prev_in;
      blk_ff      <= blk_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   // expansion buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rd_ff <= buf_mem[buf_raddr];
   end

   // key table
   always_ff @(posedge clock) begin
      if (kt_we) begin
         kt_mem[idx_ff[6:1]] <= {buf_rd_ff, low_byte_ff};
      end
      kt_rd_ff <= kt_mem[kt_raddr];
   end

   // checks
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   a_mash_rounds: assert property (@(posedge clock) disable iff (reset)
      mash_ff |-> (rnd_ff == 4'd4 || rnd_ff == 4'd10))
      else $error("MASH outside rounds 4 and 10");

   a_encrypt_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CIPH_WR && !dec_ff && !mash_ff && wi_ff == 2'd3 && rnd_ff == 4'd15)
      |=> state_ff == ST_FINISH)
      else $error("encrypt did not finish after last round");

   a_finish_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished result not presented");

endmodule
